FILE: rtl/servo_status_frame_receiver_defines.svh
// assertion macros for the servo status frame receiver
`ifndef SERVO_STATUS_FRAME_RECEIVER_DEFINES_SVH
`define SERVO_STATUS_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, skipped while reset is high
`define SSFR_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked check that also holds during reset
`define SSFR_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SSFR_ASSERT(lbl, ck, rs, prop, msg)
`define SSFR_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

FILE: rtl/ssfr_pkg.sv
// types and constants shared by the servo status frame receiver
`default_nettype none

package ssfr_pkg;

  // request codes
  localparam logic [1:0] REQ_ARM  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // receiver phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HUNT  = 2'd1;
  localparam logic [1:0] PH_SEEN  = 2'd2;
  localparam logic [1:0] PH_FRAME = 2'd3;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // final status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_SERVO    = 2'd3;

  // configuration register indexes
  localparam logic CFG_BASE_TIMEOUT     = 1'b0;
  localparam logic CFG_PER_BYTE_TIMEOUT = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICKS_W    = 17;
  localparam int unsigned POS_W      = 9;

  localparam logic [15:0] BASE_TIMEOUT_RESET     = 16'd600;
  localparam logic [7:0]  PER_BYTE_TIMEOUT_RESET = 8'd40;

  localparam logic [7:0]         SYNC_BYTE      = 8'hFF;
  localparam logic [8:0]         FRAME_OVERHEAD = 9'd6;
  localparam logic [8:0]         LEN_EXTRA      = 9'd2;
  localparam logic [POS_W-1:0]   HEADER_BYTES   = 9'd3;
  localparam logic [TICKS_W-1:0] TICKS_MAX      = 17'h1FFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] expected_payload_len;
  } req_t;

  typedef struct packed {
    logic       valid;
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] status_code;
    logic [7:0] servo_id;
    logic [7:0] error_bits;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ssfr_if.sv
// request and result channel interfaces
`default_nettype none

interface ssfr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] expected_payload_len;

  modport source (output valid, output req_type, output rx_byte,
                  output expected_payload_len, input ready);
  modport sink (input valid, input req_type, input rx_byte,
                input expected_payload_len, output ready);
endinterface

interface ssfr_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [1:0] status_code;
  logic [7:0] servo_id;
  logic [7:0] error_bits;

  modport source (output valid, output out_kind, output payload_byte,
                  output payload_index, output status_code, output servo_id,
                  output error_bits, input ready);
  modport sink (input valid, input out_kind, input payload_byte,
                input payload_index, input status_code, input servo_id,
                input error_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssfr_frame_core.sv
// frame state registers and per-request update logic
`default_nettype none
`include "servo_status_frame_receiver_defines.svh"

module ssfr_frame_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire ssfr_pkg::req_t      req,
  input  wire logic [15:0]         base_ticks,
  input  wire logic [7:0]          per_byte_ticks,
  output ssfr_pkg::res_t           res
);
  import ssfr_pkg::*;

  logic [1:0]         phase, phase_next;
  logic [7:0]         expected_len, expected_len_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [7:0]         received_id, received_id_next;
  logic [7:0]         received_error, received_error_next;
  logic               length_mismatch, length_mismatch_next;

  logic [8:0]         frame_bytes;
  logic [16:0]        byte_ticks;
  logic [17:0]        deadline_sum;
  logic [TICKS_W-1:0] deadline;
  logic [8:0]         len_field;
  logic [POS_W-1:0]   last_position;

  // deadline = base + (len + 6) * per_byte, saturated to the counter range
  assign frame_bytes  = {1'b0, req.expected_payload_len} + FRAME_OVERHEAD;
  assign byte_ticks   = {8'b0, frame_bytes} * {9'b0, per_byte_ticks};
  assign deadline_sum = {2'b00, base_ticks} + {1'b0, byte_ticks};
  assign deadline     = deadline_sum[17] ? TICKS_MAX : deadline_sum[16:0];

  assign len_field     = {1'b0, expected_len} + LEN_EXTRA;
  assign last_position = HEADER_BYTES + {1'b0, expected_len};

  always_comb begin
    phase_next           = phase;
    expected_len_next    = expected_len;
    byte_position_next   = byte_position;
    running_sum_next     = running_sum;
    ticks_left_next      = ticks_left;
    received_id_next     = received_id;
    received_error_next  = received_error;
    length_mismatch_next = length_mismatch;
    res                  = '0;

    if (take) begin
      case (req.req_type)
        REQ_ARM: begin
          phase_next           = PH_HUNT;
          expected_len_next    = req.expected_payload_len;
          byte_position_next   = '0;
          running_sum_next     = '0;
          ticks_left_next      = deadline;
          received_id_next     = '0;
          received_error_next  = '0;
          length_mismatch_next = 1'b0;
        end
        REQ_TICK: begin
          if (phase != PH_IDLE) begin
            if (ticks_left <= TICKS_W'(1)) begin
              ticks_left_next  = '0;
              res.valid        = 1'b1;
              res.out_kind     = KIND_FINAL;
              res.status_code  = ST_TIMEOUT;
              res.servo_id     = received_id;
              res.error_bits   = received_error;
              phase_next       = PH_IDLE;
            end else begin
              ticks_left_next = ticks_left - TICKS_W'(1);
            end
          end
        end
        REQ_BYTE: begin
          if (phase != PH_IDLE) begin
            if (ticks_left == '0) begin
              // zero deadline: byte is dropped and the frame times out
              res.valid       = 1'b1;
              res.out_kind    = KIND_FINAL;
              res.status_code = ST_TIMEOUT;
              res.servo_id    = received_id;
              res.error_bits  = received_error;
              phase_next      = PH_IDLE;
            end else begin
              case (phase)
                PH_HUNT: begin
                  if (req.rx_byte == SYNC_BYTE) phase_next = PH_SEEN;
                end
                PH_SEEN: begin
                  if (req.rx_byte == SYNC_BYTE) begin
                    phase_next         = PH_FRAME;
                    byte_position_next = '0;
                    running_sum_next   = '0;
                  end else begin
                    phase_next = PH_HUNT;
                  end
                end
                PH_FRAME: begin
                  if (byte_position == last_position) begin
                    // checksum byte closes the frame
                    res.valid      = 1'b1;
                    res.out_kind   = KIND_FINAL;
                    res.servo_id   = received_id;
                    res.error_bits = received_error;
                    phase_next     = PH_IDLE;
                    if (length_mismatch)
                      res.status_code = ST_TIMEOUT;
                    else if (~running_sum != req.rx_byte)
                      res.status_code = ST_CHECKSUM;
                    else if (received_error != 8'd0)
                      res.status_code = ST_SERVO;
                    else
                      res.status_code = ST_OK;
                  end else begin
                    running_sum_next   = running_sum + req.rx_byte;
                    byte_position_next = byte_position + POS_W'(1);
                    case (byte_position)
                      POS_W'(0): received_id_next = req.rx_byte;
                      POS_W'(1): begin
                        if (len_field[8] || req.rx_byte != len_field[7:0])
                          length_mismatch_next = 1'b1;
                      end
                      POS_W'(2): received_error_next = req.rx_byte;
                      default: begin
                        res.valid         = 1'b1;
                        res.out_kind      = KIND_PAYLOAD;
                        res.payload_byte  = req.rx_byte;
                        res.payload_index = 8'(byte_position - HEADER_BYTES);
                      end
                    endcase
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      expected_len    <= '0;
      byte_position   <= '0;
      running_sum     <= '0;
      ticks_left      <= '0;
      received_id     <= '0;
      received_error  <= '0;
      length_mismatch <= 1'b0;
    end else begin
      phase           <= phase_next;
      expected_len    <= expected_len_next;
      byte_position   <= byte_position_next;
      running_sum     <= running_sum_next;
      ticks_left      <= ticks_left_next;
      received_id     <= received_id_next;
      received_error  <= received_error_next;
      length_mismatch <= length_mismatch_next;
    end
  end

  `SSFR_ASSERT(a_idle_silent, clk, rst, (take && phase == PH_IDLE && req.req_type != REQ_ARM) |-> !res.valid, "result from idle receiver")
  `SSFR_ASSERT(a_final_idles, clk, rst, (take && res.valid && res.out_kind == KIND_FINAL) |=> phase == PH_IDLE, "final result did not end the frame")
  `SSFR_ASSERT(a_arm_hunts, clk, rst, (take && req.req_type == REQ_ARM) |=> (phase == PH_HUNT && byte_position == '0 && !length_mismatch), "arm did not restart reception")
  `SSFR_ASSERT(a_pos_bound, clk, rst, (phase == PH_FRAME) |-> byte_position <= last_position, "frame position ran past checksum")

endmodule

`default_nettype wire

FILE: rtl/servo_status_frame_receiver.sv
// servo status frame receiver top level
//
// requests come in on req: arm (sets payload length and deadline), a received
// serial byte, or one time tick. results leave on res: one per payload byte
// (out_kind 0, with its index) and one final status per frame (out_kind 1:
// ok, timeout or bad length, checksum error, servo error, plus id and error).
// bytes are dropped until two 0xff bytes arrive in a row; an arm while busy
// restarts reception without a result for the old frame.
// each request is handled in the cycle it is taken; its result, if any, sits
// in the result register from the next cycle on, and one request is taken
// every cycle while the result side keeps up.
// the result register is the only buffer: while res is stalled with a result
// pending, req.ready drops and no request is taken.
// reset (rst, synchronous) idles the receiver, empties the result register and
// loads the timeout registers with 600 and 40 ticks. the user must write the
// registers via cfg_we / cfg_index / cfg_data only while idle; the block does not check.
`default_nettype none
`include "servo_status_frame_receiver_defines.svh"

module servo_status_frame_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_data,
  ssfr_req_if.sink                             req,
  ssfr_res_if.source                           res
);
  import ssfr_pkg::*;

  logic [15:0] base_ticks;
  logic [7:0]  per_byte_ticks;
  logic        take;
  req_t        req_bus;
  res_t        core_res;
  res_t        res_q;
  logic        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ticks     <= BASE_TIMEOUT_RESET;
      per_byte_ticks <= PER_BYTE_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_TIMEOUT:     base_ticks     <= cfg_data[15:0];
        CFG_PER_BYTE_TIMEOUT: per_byte_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // take a request whenever the result register is free or draining
  assign req.ready = !out_valid || res.ready;
  assign take      = req.valid && req.ready;

  assign req_bus.req_type             = req.req_type;
  assign req_bus.rx_byte              = req.rx_byte;
  assign req_bus.expected_payload_len = req.expected_payload_len;

  ssfr_frame_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .req            (req_bus),
    .base_ticks     (base_ticks),
    .per_byte_ticks (per_byte_ticks),
    .res            (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= core_res.valid;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && core_res.valid) res_q <= core_res;
  end

  assign res.valid         = out_valid;
  assign res.out_kind      = res_q.out_kind;
  assign res.payload_byte  = res_q.payload_byte;
  assign res.payload_index = res_q.payload_index;
  assign res.status_code   = res_q.status_code;
  assign res.servo_id      = res_q.servo_id;
  assign res.error_bits    = res_q.error_bits;

  `SSFR_ASSERT(a_result_lands, clk, rst, (take && core_res.valid) |=> out_valid, "result lost on the way to the output register")
  `SSFR_ASSERT(a_no_overwrite, clk, rst, (out_valid && !res.ready) |-> !take, "request taken over a pending result")
  `SSFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result register not empty after reset")

endmodule

`default_nettype wire
